@@ rtl/core/mp2d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants, types and codes of the padded 2-D max pooling core.
// ----------------------------------------------------------------------------
package mp2d_pkg;

	localparam int MAX_COLS    = 256;
	localparam int MAX_WINDOW  = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int ROW_LIMIT   = 256;
	localparam int RESULT_CAP  = 16;

	localparam int COL_BITS    = $clog2(MAX_COLS);
	localparam int WIN_BITS    = $clog2(MAX_WINDOW);
	localparam int ADDR_BITS   = COL_BITS + WIN_BITS;
	localparam int STORE_DEPTH = MAX_WINDOW * MAX_COLS;
	localparam int CNT_BITS    = $clog2(RESULT_CAP);
	localparam int POS_BITS    = 9;
	localparam int OFF_BITS    = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 9;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW = 3'd0,
		REG_STEP   = 3'd1,
		REG_BORDER = 3'd2,
		REG_ROWS   = 3'd3,
		REG_COLS   = 3'd4
	} reg_idx_t;

	// Clamped geometry as used by both halves of the datapath.
	typedef struct packed {
		logic [3:0]          k;
		logic [3:0]          s;
		logic [1:0]          b;
		logic [POS_BITS-1:0] rows;
		logic [POS_BITS-1:0] cols;
		logic [OFF_BITS-1:0] lim_r;
		logic [OFF_BITS-1:0] lim_c;
	} geom_t;

	// One classified pixel. off_* is the padded start of the first window.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] pixel;
		logic [POS_BITS-1:0]           row;
		logic [POS_BITS-1:0]           col;
		logic                          has;
		logic [POS_BITS-1:0]           i0;
		logic [OFF_BITS-1:0]           off_r;
		logic                          r_multi;
		logic [POS_BITS-1:0]           j0;
		logic [OFF_BITS-1:0]           off_c;
		logic                          c_multi;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WIN,
		B_RD,
		B_DRAIN,
		B_OUT
	} back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/mp2d_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mp2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/mp2d_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_fifo
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module mp2d_fifo import mp2d_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   count_q;

	assign full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/mp2d_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_front
// Tracks the raster position and finds which windows end at each pixel.
// ----------------------------------------------------------------------------
module mp2d_front import mp2d_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  geom_t                              geom,
	input  wire logic                          restart,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] pixel_value,
	input  wire logic                          q_full,
	output logic                               push,
	output job_t                               job
);

	logic [POS_BITS-1:0] r_q, c_q, i_q, j_q;
	logic [OFF_BITS-1:0] off_r_q, off_c_q;
	logic [OFF_BITS-1:0] pe_r, pe_c, real_r, real_c;
	logic                r_last, c_last, row_has, col_has, end_r, end_c;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Padded end and real (unpadded) end of the next window in each dimension.
	assign pe_r   = off_r_q + OFF_BITS'(geom.k) - OFF_BITS'(1);
	assign pe_c   = off_c_q + OFF_BITS'(geom.k) - OFF_BITS'(1);
	assign real_r = pe_r - OFF_BITS'(geom.b);
	assign real_c = pe_c - OFF_BITS'(geom.b);
	assign r_last = (r_q == geom.rows - POS_BITS'(1));
	assign c_last = (c_q == geom.cols - POS_BITS'(1));
	assign end_r  = (real_r == OFF_BITS'(r_q));
	assign end_c  = (real_c == OFF_BITS'(c_q));

	// On the last row or column every remaining window ends here.
	assign row_has = (pe_r <= geom.lim_r) && (end_r || r_last);
	assign col_has = (pe_c <= geom.lim_c) && (end_c || c_last);

	always_comb begin
		job.pixel   = pixel_value;
		job.row     = r_q;
		job.col     = c_q;
		job.has     = row_has && col_has;
		job.i0      = i_q;
		job.off_r   = off_r_q;
		job.r_multi = r_last;
		job.j0      = j_q;
		job.off_c   = off_c_q;
		job.c_multi = c_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			c_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			off_r_q <= '0;
			off_c_q <= '0;
		end else if (restart) begin
			r_q     <= '0;
			c_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			off_r_q <= '0;
			off_c_q <= '0;
		end else if (push) begin
			if (c_last) begin
				c_q     <= '0;
				j_q     <= '0;
				off_c_q <= '0;
				if (r_last) begin
					r_q     <= '0;
					i_q     <= '0;
					off_r_q <= '0;
				end else begin
					r_q <= r_q + POS_BITS'(1);
					if (end_r) begin
						i_q     <= i_q + POS_BITS'(1);
						off_r_q <= off_r_q + OFF_BITS'(geom.s);
					end
				end
			end else begin
				c_q <= c_q + POS_BITS'(1);
				if (end_c) begin
					j_q     <= j_q + POS_BITS'(1);
					off_c_q <= off_c_q + OFF_BITS'(geom.s);
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/mp2d_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_back
// Stores each pixel in the line store and scans the windows that end there.
// ----------------------------------------------------------------------------
module mp2d_back import mp2d_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  geom_t                        geom,
	input  job_t                         head,
	input  wire logic                    q_empty,
	output logic                         pop,
	output logic                         ram_we,
	output logic [ADDR_BITS-1:0]         ram_waddr,
	output logic [SAMPLE_BITS-1:0]       ram_wdata,
	output logic                         ram_re,
	output logic [ADDR_BITS-1:0]         ram_raddr,
	input  wire logic [SAMPLE_BITS-1:0]  ram_rdata,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [SAMPLE_BITS-1:0] max_value,
	output logic [POS_BITS-1:0]          out_row,
	output logic [POS_BITS-1:0]          out_col,
	output logic                         channel_done
);

	back_state_t state_q, state_d;
	job_t        job_q;

	logic [POS_BITS-1:0]           cur_i_q, cur_j_q;
	logic [OFF_BITS-1:0]           off_r_q, off_c_q;
	logic [CNT_BITS-1:0]           n_q;
	logic [POS_BITS-1:0]           re_q, cs_q, ce_q, rd_r_q, rd_c_q;
	logic signed [SAMPLE_BITS-1:0] acc_q;
	logic                          pend_q;

	logic [OFF_BITS-1:0] pe_r, pe_c, rend, cend, nxt_off_r, nxt_off_c, nxt_pe_r, nxt_pe_c;
	logic [POS_BITS-1:0] rs, re, cs, ce;
	logic                pad, more_r, more_c, room, fire, rd_last;

	assign pe_r = off_r_q + OFF_BITS'(geom.k) - OFF_BITS'(1);
	assign pe_c = off_c_q + OFF_BITS'(geom.k) - OFF_BITS'(1);
	assign rend = pe_r - OFF_BITS'(geom.b);
	assign cend = pe_c - OFF_BITS'(geom.b);

	always_comb begin
		rs = (off_r_q >= OFF_BITS'(geom.b)) ? POS_BITS'(off_r_q - OFF_BITS'(geom.b)) : '0;
		cs = (off_c_q >= OFF_BITS'(geom.b)) ? POS_BITS'(off_c_q - OFF_BITS'(geom.b)) : '0;
		re = (rend > OFF_BITS'(geom.rows - POS_BITS'(1))) ? geom.rows - POS_BITS'(1)
		                                                   : POS_BITS'(rend);
		ce = (cend > OFF_BITS'(geom.cols - POS_BITS'(1))) ? geom.cols - POS_BITS'(1)
		                                                   : POS_BITS'(cend);
		pad = (off_r_q < OFF_BITS'(geom.b)) || (off_c_q < OFF_BITS'(geom.b)) ||
		      (pe_r >= OFF_BITS'(geom.rows) + OFF_BITS'(geom.b)) ||
		      (pe_c >= OFF_BITS'(geom.cols) + OFF_BITS'(geom.b));
	end

	assign nxt_off_r = off_r_q + OFF_BITS'(geom.s);
	assign nxt_off_c = off_c_q + OFF_BITS'(geom.s);
	assign nxt_pe_r  = nxt_off_r + OFF_BITS'(geom.k) - OFF_BITS'(1);
	assign nxt_pe_c  = nxt_off_c + OFF_BITS'(geom.k) - OFF_BITS'(1);
	assign more_r    = job_q.r_multi && (nxt_pe_r <= geom.lim_r);
	assign more_c    = job_q.c_multi && (nxt_pe_c <= geom.lim_c);
	assign room      = (n_q != CNT_BITS'(RESULT_CAP - 1));
	assign fire      = !out_valid || out_ready;
	assign rd_last   = (rd_c_q == ce_q) && (rd_r_q == re_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty && head.has) begin
					state_d = B_WIN;
				end
			end
			B_WIN:   state_d = B_RD;
			B_RD: begin
				if (rd_last) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: state_d = B_OUT;
			B_OUT: begin
				if (fire) begin
					state_d = ((more_c || more_r) && room) ? B_WIN : B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == B_IDLE) && !q_empty;
		ram_we    = pop;
		ram_waddr = {head.row[WIN_BITS-1:0], head.col[COL_BITS-1:0]};
		ram_wdata = head.pixel;
		ram_re    = (state_q == B_RD);
		ram_raddr = {rd_r_q[WIN_BITS-1:0], rd_c_q[COL_BITS-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= (state_q == B_RD);
			if (state_q == B_OUT && fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && $signed(ram_rdata) > acc_q) begin
			acc_q <= $signed(ram_rdata);
		end
		unique case (state_q)
			B_IDLE: begin
				job_q   <= head;
				cur_i_q <= head.i0;
				off_r_q <= head.off_r;
				cur_j_q <= head.j0;
				off_c_q <= head.off_c;
				n_q     <= '0;
			end
			B_WIN: begin
				re_q   <= re;
				cs_q   <= cs;
				ce_q   <= ce;
				rd_r_q <= rs;
				rd_c_q <= cs;
				// A window that overlaps the border starts from the zero padding.
				acc_q  <= pad ? '0 : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			end
			B_RD: begin
				if (rd_c_q == ce_q) begin
					rd_c_q <= cs_q;
					rd_r_q <= rd_r_q + POS_BITS'(1);
				end else begin
					rd_c_q <= rd_c_q + POS_BITS'(1);
				end
			end
			B_DRAIN: begin
			end
			B_OUT: begin
				if (fire) begin
					max_value    <= acc_q;
					out_row      <= cur_i_q;
					out_col      <= cur_j_q;
					channel_done <= (nxt_pe_r > geom.lim_r) && (nxt_pe_c > geom.lim_c);
					n_q          <= n_q + CNT_BITS'(1);
					if (more_c) begin
						cur_j_q <= cur_j_q + POS_BITS'(1);
						off_c_q <= nxt_off_c;
					end else begin
						cur_i_q <= cur_i_q + POS_BITS'(1);
						off_r_q <= nxt_off_r;
						cur_j_q <= job_q.j0;
						off_c_q <= job_q.off_c;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/max_pool_2d_padded_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d_padded_core
// Streaming 2-D max pooling of one channel with a zero border.
// ----------------------------------------------------------------------------
// Pixels enter on the in_valid/in_ready channel in raster order. Each pixel
// is placed in a queue; the back end writes it to the line store and then,
// for every window whose last real pixel it is, reads the window's stored
// samples one per cycle from the single read port of the line store.
// A result item carries the maximum, the window's row and column, and
// channel_done on the channel's final window.
// The back end pops each pixel and writes it to the line store in its idle
// state. Each window that the pixel closes then passes through B_WIN, B_RD
// (one read for each sample of the window's real area h * w), B_DRAIN and
// B_OUT, which waits for the output channel. Up to 16 results come from one
// pixel. The front end takes a pixel every cycle while the four-entry queue
// has room.
// Configuration writes go through cfg_we/cfg_index/cfg_data; a write to one
// of the five registers restarts the channel. Reset restores the default
// geometry and empties the queue. A stalled out_ready holds the result; the
// back end and then the queue fill and in_ready falls.
// ----------------------------------------------------------------------------
module max_pool_2d_padded_core import mp2d_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] pixel_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      max_value,
	output logic [POS_BITS-1:0]                out_row,
	output logic [POS_BITS-1:0]                out_col,
	output logic                               channel_done,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

	logic [3:0]          window_q, step_q;
	logic [1:0]          border_q;
	logic [POS_BITS-1:0] rows_q, cols_q;
	logic                restart;
	geom_t               geom;

	job_t                 push_job, head;
	logic                 push, pop, q_full, q_empty;
	logic                 ram_we, ram_re;
	logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

	assign restart = cfg_we && (cfg_index <= REG_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 4'd2;
			step_q   <= 4'd2;
			border_q <= 2'd0;
			rows_q   <= POS_BITS'(ROW_LIMIT);
			cols_q   <= POS_BITS'(MAX_COLS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW: window_q <= cfg_data[3:0];
				REG_STEP:   step_q   <= cfg_data[3:0];
				REG_BORDER: border_q <= cfg_data[1:0];
				REG_ROWS:   rows_q   <= cfg_data[POS_BITS-1:0];
				REG_COLS:   cols_q   <= cfg_data[POS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (window_q == '0) begin
			geom.k = 4'd1;
		end else if (window_q > 4'(MAX_WINDOW)) begin
			geom.k = 4'(MAX_WINDOW);
		end else begin
			geom.k = window_q;
		end
		geom.s = (step_q == '0) ? 4'd1 : step_q;
		geom.b = (4'(border_q) > geom.k - 4'd1) ? 2'(geom.k - 4'd1) : border_q;
		if (rows_q == '0) begin
			geom.rows = POS_BITS'(1);
		end else if (rows_q > POS_BITS'(ROW_LIMIT)) begin
			geom.rows = POS_BITS'(ROW_LIMIT);
		end else begin
			geom.rows = rows_q;
		end
		if (cols_q == '0) begin
			geom.cols = POS_BITS'(1);
		end else if (cols_q > POS_BITS'(MAX_COLS)) begin
			geom.cols = POS_BITS'(MAX_COLS);
		end else begin
			geom.cols = cols_q;
		end
		// Last padded index in each dimension.
		geom.lim_r = OFF_BITS'(geom.rows) - OFF_BITS'(1) + OFF_BITS'({geom.b, 1'b0});
		geom.lim_c = OFF_BITS'(geom.cols) - OFF_BITS'(1) + OFF_BITS'({geom.b, 1'b0});
	end

	mp2d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.restart     (restart),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job)
	);

	mp2d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	mp2d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mp2d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_value    (max_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.channel_done (channel_done)
	);

endmodule
`default_nettype wire

@@ rtl/core/mp2d_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks of the max pooling core, bound to the top level.
// ----------------------------------------------------------------------------
module mp2d_checker import mp2d_pkg::*; (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic signed [SAMPLE_BITS-1:0] pixel_value,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [SAMPLE_BITS-1:0] max_value,
	input wire logic [POS_BITS-1:0]           out_row,
	input wire logic [POS_BITS-1:0]           out_col,
	input wire logic                          channel_done,
	input wire logic                          cfg_we
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_q <= 1'b1;
		end
	end

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(max_value) &&
		$stable(out_row) && $stable(out_col) && $stable(channel_done))
		else $error("stalled result changed");

	// No result before the first item has entered.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("result without any item");

	// Window indexes stay inside the largest padded image.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row <= POS_BITS'(261)) && (out_col <= POS_BITS'(261)))
		else $error("window index out of range");

	// A waiting input item keeps its pixel until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pixel_value))
		else $error("waiting input item changed");

	// Register writes only come while no result is waiting.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !out_valid)
		else $error("register write with a result waiting");

endmodule

bind max_pool_2d_padded_core mp2d_checker u_mp2d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.pixel_value  (pixel_value),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.max_value    (max_value),
	.out_row      (out_row),
	.out_col      (out_col),
	.channel_done (channel_done),
	.cfg_we       (cfg_we)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the padded 2-D max pooling core.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order under several window, step, border and
// image geometries. A local pooling model predicts every window maximum with
// its row, column and channel_done flag. The monitor checks each result
// against the oldest prediction. Both sides idle and stall at random, but in the last phase.
// ----------------------------------------------------------------------------
module tb;
	import mp2d_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd6;
	localparam int IDLE_WAIT = 300;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] maxv;
		logic [POS_BITS-1:0]           row;
		logic [POS_BITS-1:0]           col;
		logic                          done;
	} pool_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] pixel_value;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [SAMPLE_BITS-1:0] max_value;
	logic [POS_BITS-1:0]           out_row;
	logic [POS_BITS-1:0]           out_col;
	logic                          channel_done;
	logic                          cfg_we;
	logic [CFG_IDX_BITS-1:0]       cfg_index;
	logic [CFG_DATA_BITS-1:0]      cfg_data;

	max_pool_2d_padded_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready), .max_value(max_value),
		.out_row(out_row), .out_col(out_col), .channel_done(channel_done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Model state: raw register values and the streaming position.
	logic [3:0]                    win_reg;
	logic [3:0]                    step_reg;
	logic [1:0]                    border_reg;
	logic [8:0]                    rows_reg;
	logic [8:0]                    cols_reg;
	logic signed [SAMPLE_BITS-1:0] rows_buf [MAX_WINDOW][MAX_COLS];
	int unsigned                   cur_row, cur_col, windows_left;

	logic signed [SAMPLE_BITS-1:0] pixel_q [$];
	pool_result_t                  window_q [$];
	int                            send_idle_pct, recv_idle_pct;
	bit                            hold_pixels, pixel_taken;
	int                            errors, pixels_sent, windows_seen, geometries;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Timeout with %0d windows outstanding", window_q.size());
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned last_real(int unsigned idx, int unsigned k,
			int unsigned s, int unsigned b, int unsigned n);
		int unsigned e;
		e = idx * s + k - 1;
		e = (e >= b) ? e - b : 0;
		return (e > n - 1) ? n - 1 : e;
	endfunction

	task automatic predict_windows(logic signed [SAMPLE_BITS-1:0] pix);
		int unsigned k, s, b, rows, cols, orows, ocols, rs, cs, re, ce, r0, c0;
		int m, n;
		bit pad;
		pool_result_t res;
		k = (win_reg < 1) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
		s = (step_reg < 1) ? 1 : step_reg;
		b = (border_reg > k - 1) ? k - 1 : border_reg;
		rows = (rows_reg < 1) ? 1 : ((rows_reg > ROW_LIMIT) ? ROW_LIMIT : rows_reg);
		cols = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
		orows = (rows + 2 * b >= k) ? (rows + 2 * b - k) / s + 1 : 0;
		ocols = (cols + 2 * b >= k) ? (cols + 2 * b - k) / s + 1 : 0;
		n = 0;
		if (cur_row >= rows || cur_col >= cols) begin
			cur_row = 0;
			cur_col = 0;
		end
		if (cur_row == 0 && cur_col == 0)
			windows_left = orows * ocols;
		rows_buf[cur_row % MAX_WINDOW][cur_col % MAX_COLS] = pix;
		for (int unsigned i = 0; i < orows; i++) begin
			if (last_real(i, k, s, b, rows) != cur_row)
				continue;
			for (int unsigned j = 0; j < ocols; j++) begin
				if (last_real(j, k, s, b, cols) != cur_col)
					continue;
				if (n >= RESULT_CAP)
					break;
				res.done = 1'b0;
				if (windows_left > 0) begin
					windows_left--;
					res.done = (windows_left == 0);
				end
				r0 = i * s;
				c0 = j * s;
				rs = (r0 >= b) ? r0 - b : 0;
				cs = (c0 >= b) ? c0 - b : 0;
				re = last_real(i, k, s, b, rows);
				ce = last_real(j, k, s, b, cols);
				pad = (r0 < b) || (c0 < b) || (r0 + k > rows + b) || (c0 + k > cols + b);
				m = pad ? 0 : -40000;
				for (int unsigned r = rs; r <= re; r++)
					for (int unsigned c = cs; c <= ce; c++)
						if (int'(rows_buf[r % MAX_WINDOW][c % MAX_COLS]) > m)
							m = rows_buf[r % MAX_WINDOW][c % MAX_COLS];
				res.maxv = m[SAMPLE_BITS-1:0];
				res.row = i[POS_BITS-1:0];
				res.col = j[POS_BITS-1:0];
				window_q.insert(window_q.size(), res);
				n++;
			end
		end
		cur_col++;
		if (cur_col >= cols) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= rows)
				cur_row = 0;
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("Mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
	endtask

	// Monitor: applies register writes and accepted pixels to the model and
	// checks each accepted result.
	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW: win_reg = cfg_data[3:0];
					REG_STEP:   step_reg = cfg_data[3:0];
					REG_BORDER: border_reg = cfg_data[1:0];
					REG_ROWS:   rows_reg = cfg_data;
					REG_COLS:   cols_reg = cfg_data;
					default: ;
				endcase
				if (cfg_index <= REG_COLS) begin
					cur_row = 0;
					cur_col = 0;
					windows_left = 0;
				end
			end
			if (in_valid && in_ready) begin
				predict_windows(pixel_value);
				pixel_taken = 1'b1;
				pixels_sent++;
			end
			if (out_valid && out_ready) begin
				windows_seen++;
				if (window_q.size() == 0) begin
					report_mismatch("windows pending", 0, 1);
				end else begin
					want = window_q.pop_front();
					if (max_value !== want.maxv)
						report_mismatch("max_value", max_value, want.maxv);
					if (out_row !== want.row)
						report_mismatch("out_row", out_row, want.row);
					if (out_col !== want.col)
						report_mismatch("out_col", out_col, want.col);
					if (channel_done !== want.done)
						report_mismatch("channel_done", channel_done, want.done);
				end
			end
		end
	end

	// Driver: a pixel stays on the port until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !pixel_taken) begin
			end else if (pixel_q.size() > 0 && !hold_pixels &&
					$urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				pixel_value <= pixel_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
			pixel_taken = 1'b0;
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pixel_q.size() > 0 || in_valid || window_q.size() > 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_geometry(int unsigned k, int unsigned s, int unsigned b,
			int unsigned rows, int unsigned cols);
		wait_idle();
		write_reg(REG_WINDOW, k);
		write_reg(REG_STEP, s);
		write_reg(REG_BORDER, b);
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
		geometries++;
	endtask

	task automatic queue_pixel(logic signed [SAMPLE_BITS-1:0] pix);
		pixel_q.insert(pixel_q.size(), pix);
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++)
			queue_pixel(16'($urandom_range(16'hFFFF)));
	endtask

	initial begin
		int unsigned rows, cols, channel, npix;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pixel_value = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW;
		cfg_data = '0;
		win_reg = 4'd2;
		step_reg = 4'd2;
		border_reg = 2'd0;
		rows_reg = 9'd256;
		cols_reg = 9'd256;
		cur_row = 0;
		cur_col = 0;
		windows_left = 0;
		hold_pixels = 1'b0;
		pixel_taken = 1'b0;
		errors = 0;
		pixels_sent = 0;
		windows_seen = 0;
		geometries = 0;
		send_idle_pct = 26;
		recv_idle_pct = 80;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single pixel image: every pixel is its own window and ends a channel.
		set_geometry(1, 1, 0, 1, 1);
		queue_pixel(16'sh7FFF);
		queue_pixel(-16'sh8000);
		queue_pixel(16'sh0000);
		// Window wider than the image: the zero border sets the maximum.
		set_geometry(8, 8, 3, 3, 4);
		for (int i = 0; i < 12; i++)
			queue_pixel(-16'sd1 - 16'(i * 700));
		// Zero window and step count as one; the border is clipped to zero.
		set_geometry(0, 0, 3, 0, 2);
		queue_pixel(-16'sd5);
		queue_pixel(16'sd9);
		// Oversized window and step: window beyond the padded image, no output.
		set_geometry(15, 15, 2, 2, 2);
		write_reg(REG_UNUSED, 9'h1FF);
		queue_random(4);
		// Row and column counts above range clamp to the largest image.
		set_geometry(2, 2, 0, 511, 300);
		queue_random(2);
		// Padded 3x3 windows at step one: the last pixel closes several.
		set_geometry(3, 1, 1, 3, 3);
		queue_random(9);

		// Random geometries on small images; the idle pattern changes as the
		// pixel count grows, so every phase sees at least one channel.
		channel = 0;
		while (pixels_sent + pixel_q.size() < 120) begin
			if (pixels_sent + pixel_q.size() >= 88) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (pixels_sent + pixel_q.size() >= 56) begin
				send_idle_pct = 80;
				recv_idle_pct = 26;
			end
			rows = $urandom_range(1, 4);
			cols = $urandom_range(1, 4);
			set_geometry($urandom_range(1, 8), $urandom_range(1, 8),
				$urandom_range(0, 3), rows, cols);
			npix = rows * cols * $urandom_range(1, 2);
			if ($urandom_range(9) == 0)
				npix = $urandom_range(1, rows * cols);
			if ($urandom_range(7) == 0)
				write_reg(REG_UNUSED, $urandom_range(511));
			queue_random(npix);
			if (channel == 1) begin
				while (pixel_q.size() > npix / 2)
					@(posedge clk);
				hold_pixels = 1'b1;
				while (window_q.size() > 0 || in_valid)
					@(posedge clk);
				hold_pixels = 1'b0;
			end
			channel++;
		end
		wait_idle();

		$display("Sent %0d pixels over %0d geometries and checked %0d windows.",
			pixels_sent, geometries, windows_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ max_pool_2d_padded_core.f @@
rtl/core/mp2d_pkg.sv
rtl/core/mp2d_ram.sv
rtl/core/mp2d_fifo.sv
rtl/core/mp2d_front.sv
rtl/core/mp2d_back.sv
rtl/core/max_pool_2d_padded_core.sv
rtl/core/mp2d_checker.sv
tb/sv/tb.sv
